// ===== hw/rtl/sfla_pkg.sv =====
// shared types and constants for the segregated free-list allocator
package sfla_pkg;

  localparam int ADDR_W     = 32;
  localparam int SIZE_W     = 16;
  localparam int TDATA_W    = 48;
  localparam int IN_TUSER_W = 1;
  localparam int STATUS_W   = 2;
  localparam int LOG_W      = 4;
  localparam int BIN_CALC_W = 5;

  localparam logic [SIZE_W-1:0]     BIN0_LIMIT     = 16'd64;
  localparam logic [SIZE_W-1:0]     BIN1_LIMIT     = 16'd256;
  localparam logic [BIN_CALC_W-1:0] BIN_LOG_OFFSET = 5'd6;

  localparam logic OP_PUT   = 1'b0;
  localparam logic OP_MATCH = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_TOO_LARGE = 2'd1,
    STATUS_NO_FIT    = 2'd2,
    STATUS_FULL      = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_PUT_READ,
    ST_PUT_WRITE,
    ST_WALK,
    ST_BIN_LOAD,
    ST_CHECK,
    ST_FREE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic    load_in;
    logic    put_read;
    logic    put_write;
    logic    bin_start;
    logic    bin_inc;
    logic    walk_read;
    logic    walk_next;
    logic    unlink;
    logic    free_link;
    logic    out_load;
    status_t out_status;
  } cmd_t;

  typedef struct packed {
    logic too_big;
    logic is_match;
    logic free_avail;
    logic fresh_avail;
    logic cur_none;
    logic budget_zero;
    logic last_bin;
    logic fit;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== hw/rtl/sfla_ctrl.sv =====
// controller state machine: sequences puts, bin walks and result loads
module sfla_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  sfla_pkg::dp_stat_t stat,
  output sfla_pkg::cmd_t     cmd
);
  import sfla_pkg::*;

  state_t  state_r, state_nxt;
  status_t status_r, status_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      status_r <= STATUS_OK;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    status_nxt     = status_r;
    cmd            = '0;
    cmd.out_status = status_r;
    in_tready      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        priority if (stat.too_big) begin
          status_nxt = STATUS_TOO_LARGE;
          state_nxt  = ST_FINISH;
        end else if (stat.is_match) begin
          cmd.bin_start = 1'b1;
          state_nxt     = ST_WALK;
        end else if (stat.free_avail) begin
          cmd.put_read = 1'b1;
          state_nxt    = ST_PUT_READ;
        end else if (stat.fresh_avail) begin
          state_nxt = ST_PUT_WRITE;
        end else begin
          status_nxt = STATUS_FULL;
          state_nxt  = ST_FINISH;
        end
      end
      ST_PUT_READ: begin
        state_nxt = ST_PUT_WRITE;
      end
      ST_PUT_WRITE: begin
        cmd.put_write = 1'b1;
        status_nxt    = STATUS_OK;
        state_nxt     = ST_FINISH;
      end
      ST_WALK: begin
        priority if (stat.budget_zero) begin
          status_nxt = STATUS_NO_FIT;
          state_nxt  = ST_FINISH;
        end else if (stat.cur_none) begin
          if (stat.last_bin) begin
            status_nxt = STATUS_NO_FIT;
            state_nxt  = ST_FINISH;
          end else begin
            cmd.bin_inc = 1'b1;
            state_nxt   = ST_BIN_LOAD;
          end
        end else begin
          cmd.walk_read = 1'b1;
          state_nxt     = ST_CHECK;
        end
      end
      ST_BIN_LOAD: begin
        cmd.bin_start = 1'b1;
        state_nxt     = ST_WALK;
      end
      ST_CHECK: begin
        if (stat.fit) begin
          cmd.unlink = 1'b1;
          state_nxt  = ST_FREE;
        end else begin
          cmd.walk_next = 1'b1;
          state_nxt     = ST_WALK;
        end
      end
      ST_FREE: begin
        cmd.free_link = 1'b1;
        status_nxt    = STATUS_OK;
        state_nxt     = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/sfla_dp.sv =====
// datapath: block store memories, bin heads, free list, walk registers, result register
module sfla_dp #(
  parameter int NUM_BINS       = 8,
  parameter int MAX_BLOCK_SIZE = 16384,
  parameter int ENTRIES        = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [sfla_pkg::TDATA_W-1:0]    in_tdata,
  input  logic [sfla_pkg::IN_TUSER_W-1:0] in_tuser,
  input  sfla_pkg::cmd_t                  cmd,
  output sfla_pkg::dp_stat_t              stat,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [sfla_pkg::TDATA_W-1:0]    out_tdata,
  output logic [sfla_pkg::STATUS_W-1:0]   out_tuser
);
  import sfla_pkg::*;

  localparam int SLOT_W = $clog2(ENTRIES);
  localparam int IDX_W  = $clog2(ENTRIES + 1);
  localparam int BIN_W  = $clog2(NUM_BINS);
  localparam logic [IDX_W-1:0] NONE     = IDX_W'(ENTRIES);
  localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(NUM_BINS - 1);
  localparam logic [SIZE_W:0]  MAX_SIZE = (SIZE_W + 1)'(MAX_BLOCK_SIZE);

  logic [ADDR_W-1:0] entry_address_r [ENTRIES];
  logic [SIZE_W-1:0] entry_size_r    [ENTRIES];
  logic [IDX_W-1:0]  entry_next_r    [ENTRIES];

  logic [IDX_W-1:0]  bin_head_r [NUM_BINS];
  logic [IDX_W-1:0]  free_head_r;
  logic [IDX_W-1:0]  fresh_r;
  logic              out_valid_r;

  logic              op_r;
  logic [ADDR_W-1:0] req_addr_r;
  logic [SIZE_W-1:0] req_size_r;
  logic [BIN_W-1:0]  bin_r;
  logic              big_r;
  logic [IDX_W-1:0]  cur_r;
  logic [IDX_W-1:0]  prev_r;
  logic [IDX_W-1:0]  budget_r;
  logic [ADDR_W-1:0] found_addr_r;
  logic [SIZE_W-1:0] found_size_r;
  logic [ADDR_W-1:0] rd_addr_r;
  logic [SIZE_W-1:0] rd_size_r;
  logic [IDX_W-1:0]  rd_next_r;
  logic [TDATA_W-1:0]  out_data_r;
  logic [STATUS_W-1:0] out_user_r;

  logic [ADDR_W-1:0]     in_addr;
  logic [SIZE_W-1:0]     in_size;
  logic [LOG_W-1:0]      size_log;
  logic [BIN_CALC_W-1:0] bin_calc;
  logic [BIN_W-1:0]      in_bin;
  logic                  use_free;
  logic [IDX_W-1:0]      put_slot;
  logic                  wr_en;
  logic                  wr_full;
  logic [IDX_W-1:0]      wr_idx;
  logic [IDX_W-1:0]      wr_next;
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_idx;

  assign in_addr = in_tdata[ADDR_W-1:0];
  assign in_size = in_tdata[ADDR_W+SIZE_W-1:ADDR_W];

  // size class of the incoming size
  always_comb begin
    size_log = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if (in_size[i]) begin
        size_log = LOG_W'(i);
      end
    end
    priority if (in_size < BIN0_LIMIT) begin
      bin_calc = '0;
    end else if (in_size < BIN1_LIMIT) begin
      bin_calc = BIN_CALC_W'(1);
    end else begin
      bin_calc = {1'b0, size_log} - BIN_LOG_OFFSET;
    end
    if (bin_calc > BIN_CALC_W'(NUM_BINS - 1)) begin
      bin_calc = BIN_CALC_W'(NUM_BINS - 1);
    end
    in_bin = bin_calc[BIN_W-1:0];
  end

  assign use_free = (free_head_r != NONE);
  assign put_slot = use_free ? free_head_r : fresh_r;

  // single write port and single read port of the block store
  always_comb begin
    wr_en   = 1'b0;
    wr_full = 1'b0;
    wr_idx  = put_slot;
    wr_next = bin_head_r[bin_r];
    priority if (cmd.put_write) begin
      wr_en   = 1'b1;
      wr_full = 1'b1;
    end else if (cmd.unlink) begin
      wr_en   = (prev_r != NONE);
      wr_idx  = prev_r;
      wr_next = rd_next_r;
    end else if (cmd.free_link) begin
      wr_en   = 1'b1;
      wr_idx  = cur_r;
      wr_next = free_head_r;
    end else begin
      wr_en = 1'b0;
    end
    rd_en  = cmd.put_read | cmd.walk_read;
    rd_idx = cmd.put_read ? free_head_r : cur_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (wr_full) begin
        entry_address_r[wr_idx[SLOT_W-1:0]] <= req_addr_r;
        entry_size_r[wr_idx[SLOT_W-1:0]]    <= req_size_r;
      end
      entry_next_r[wr_idx[SLOT_W-1:0]] <= wr_next;
    end
    if (rd_en) begin
      rd_addr_r <= entry_address_r[rd_idx[SLOT_W-1:0]];
      rd_size_r <= entry_size_r[rd_idx[SLOT_W-1:0]];
      rd_next_r <= entry_next_r[rd_idx[SLOT_W-1:0]];
    end
  end

  // list heads, free list and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < NUM_BINS; b++) begin
        bin_head_r[b] <= NONE;
      end
      free_head_r <= NONE;
      fresh_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.put_write) begin
        bin_head_r[bin_r] <= put_slot;
        if (use_free) begin
          free_head_r <= rd_next_r;
        end else begin
          fresh_r <= fresh_r + IDX_W'(1);
        end
      end
      if (cmd.unlink && prev_r == NONE) begin
        bin_head_r[bin_r] <= rd_next_r;
      end
      if (cmd.free_link) begin
        free_head_r <= cur_r;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request and walk registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r         <= in_tuser[0];
      req_addr_r   <= in_addr;
      req_size_r   <= in_size;
      bin_r        <= in_bin;
      big_r        <= ({1'b0, in_size} >= MAX_SIZE);
      budget_r     <= NONE;
      found_addr_r <= '0;
      found_size_r <= '0;
    end
    if (cmd.bin_start) begin
      cur_r  <= bin_head_r[bin_r];
      prev_r <= NONE;
    end
    if (cmd.bin_inc) begin
      bin_r <= bin_r + BIN_W'(1);
    end
    if (cmd.walk_read) begin
      budget_r <= budget_r - IDX_W'(1);
    end
    if (cmd.walk_next) begin
      prev_r <= cur_r;
      cur_r  <= rd_next_r;
    end
    if (cmd.unlink) begin
      found_addr_r <= rd_addr_r;
      found_size_r <= rd_size_r;
    end
    if (cmd.out_load) begin
      out_data_r <= {found_size_r, found_addr_r};
      out_user_r <= cmd.out_status;
    end
  end

  always_comb begin
    stat.too_big     = big_r;
    stat.is_match    = (op_r == OP_MATCH);
    stat.free_avail  = use_free;
    stat.fresh_avail = (fresh_r != NONE);
    stat.cur_none    = (cur_r == NONE);
    stat.budget_zero = (budget_r == '0);
    stat.last_bin    = (bin_r == LAST_BIN);
    stat.fit         = (rd_size_r >= req_size_r);
    stat.out_free    = !out_valid_r || out_tready;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ===== hw/rtl/segregated_free_list_allocator.sv =====
// top level of the segregated free-list allocator
// throughput: one item at a time, the next beat is taken once the result is loaded;
//   the bin walk reads the block store entries one at a time through one memory port
// reset: synchronous active-low rst_n empties every bin and the free list, no clearing pass
module segregated_free_list_allocator #(
  parameter int NUM_BINS       = 8,
  parameter int MAX_BLOCK_SIZE = 16384,
  parameter int ENTRIES        = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [sfla_pkg::TDATA_W-1:0]    in_tdata,  // block_address, block_size
  input  logic [sfla_pkg::IN_TUSER_W-1:0] in_tuser,  // operation
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [sfla_pkg::TDATA_W-1:0]    out_tdata, // found_address, found_size
  output logic [sfla_pkg::STATUS_W-1:0]   out_tuser  // status
);
  import sfla_pkg::*;

  cmd_t     cmd;
  dp_stat_t stat;

  sfla_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sfla_dp #(
    .NUM_BINS       (NUM_BINS),
    .MAX_BLOCK_SIZE (MAX_BLOCK_SIZE),
    .ENTRIES        (ENTRIES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== tb/segregated_free_list_allocator_tb.sv =====
// testbench for the segregated free-list allocator: directed and random put/match traffic
`timescale 1ns / 100ps

module segregated_free_list_allocator_tb;
  import sfla_pkg::*;

  localparam int NUM_BINS       = 8;
  localparam int MAX_BLOCK_SIZE = 16384;
  localparam int ENTRIES        = 64;
  localparam int QUIET_LIMIT    = 2000;
  localparam int SETTLE_CYCLES  = 2 * ENTRIES + 2 * NUM_BINS + 8;

  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
  } alloc_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [TDATA_W-1:0]    in_tdata = '0;   // block_address, block_size
  logic [IN_TUSER_W-1:0] in_tuser = '0;   // operation
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [TDATA_W-1:0]    out_tdata;       // found_address, found_size
  logic [STATUS_W-1:0]   out_tuser;       // status

  // mirror of the block store and bins
  logic [ADDR_W-1:0] slot_addr [ENTRIES];
  logic [SIZE_W-1:0] slot_size [ENTRIES];
  int                slot_next [ENTRIES];
  bit                slot_used [ENTRIES];
  int                bin_first [NUM_BINS];
  int                stored_count;

  alloc_result_t     pending_results[$];
  int                mismatch_count = 0;
  int                quiet_cycles = 0;
  int                stall_request = 0;
  int                stall_left = 0;
  bit                in_gaps_on = 1'b1;
  bit                out_gaps_on = 1'b1;
  logic [ADDR_W-1:0] last_addr = '0;

  segregated_free_list_allocator #(
    .NUM_BINS      (NUM_BINS),
    .MAX_BLOCK_SIZE(MAX_BLOCK_SIZE),
    .ENTRIES       (ENTRIES)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int size_bin(logic [SIZE_W-1:0] sz);
    int lg = 0;
    int v = int'(sz);
    int b;
    if (sz < BIN0_LIMIT) return 0;
    if (sz < BIN1_LIMIT) return 1;
    while (v > 1) begin
      v = v >> 1;
      lg++;
    end
    b = lg - 6;
    if (b > NUM_BINS - 1) b = NUM_BINS - 1;
    return b;
  endfunction

  function automatic void clear_store();
    for (int i = 0; i < ENTRIES; i++) begin
      slot_addr[i] = '0;
      slot_size[i] = '0;
      slot_next[i] = ENTRIES;
      slot_used[i] = 1'b0;
    end
    for (int b = 0; b < NUM_BINS; b++) bin_first[b] = ENTRIES;
    stored_count = 0;
  endfunction

  // updates the mirror and returns the result beat the block must produce
  function automatic alloc_result_t apply_alloc_op(logic op, logic [ADDR_W-1:0] addr,
                                                   logic [SIZE_W-1:0] size);
    alloc_result_t res;
    int slot;
    int b;
    int budget;
    int prev;
    int cur;
    bit found;
    res.status = STATUS_OK;
    res.addr = '0;
    res.size = '0;
    found = 1'b0;
    budget = ENTRIES;
    if (size >= MAX_BLOCK_SIZE) begin
      res.status = STATUS_TOO_LARGE;
    end else if (op == OP_PUT) begin
      slot = ENTRIES;
      for (int i = ENTRIES - 1; i >= 0; i--) if (!slot_used[i]) slot = i;
      if (slot == ENTRIES) begin
        res.status = STATUS_FULL;
      end else begin
        b = size_bin(size);
        slot_addr[slot] = addr;
        slot_size[slot] = size;
        slot_next[slot] = bin_first[b];
        slot_used[slot] = 1'b1;
        bin_first[b] = slot;
        stored_count++;
      end
    end else begin
      for (b = size_bin(size); b < NUM_BINS && !found; b++) begin
        prev = ENTRIES;
        cur = bin_first[b];
        while (cur < ENTRIES && budget > 0 && !found) begin
          budget--;
          if (slot_size[cur] >= size) begin
            if (prev == ENTRIES) bin_first[b] = slot_next[cur];
            else slot_next[prev] = slot_next[cur];
            slot_used[cur] = 1'b0;
            res.addr = slot_addr[cur];
            res.size = slot_size[cur];
            stored_count--;
            found = 1'b1;
          end else begin
            prev = cur;
            cur = slot_next[cur];
          end
        end
      end
      if (!found) res.status = STATUS_NO_FIT;
    end
    return res;
  endfunction

  function automatic logic [SIZE_W-1:0] pick_block_size();
    int pick;
    int base;
    pick = $urandom_range(99);
    base = 1 << $urandom_range(14, 6);
    if (pick < 30) return SIZE_W'($urandom_range(63));
    if (pick < 50) return SIZE_W'($urandom_range(255, 64));
    if (pick < 65) return SIZE_W'(base - 1 + int'($urandom_range(2)));
    if (pick < 94) return SIZE_W'($urandom_range(16383, 256));
    return SIZE_W'($urandom_range(65535, 16384));
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("%0t: %s differs, expected 0x%08h got 0x%08h", $time, what, want, got);
    mismatch_count++;
  endtask

  task automatic send_item(input logic op, input logic [ADDR_W-1:0] addr,
                           input logic [SIZE_W-1:0] size);
    while (in_gaps_on && $urandom_range(99) < 33) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {size, addr};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(apply_alloc_op(op, addr, size));
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic run_random_traffic(input int n_items);
    logic              op;
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
    int                put_pct;
    int                pick;
    int                slot;
    for (int i = 0; i < n_items; i++) begin
      put_pct = (stored_count < 20) ? 70 : (stored_count > 56) ? 35 : 50;
      op = ($urandom_range(99) < put_pct) ? OP_PUT : OP_MATCH;
      pick = $urandom_range(99);
      if (pick < 80) addr = $urandom;
      else if (pick < 85) addr = '0;
      else if (pick < 90) addr = '1;
      else addr = last_addr;
      size = pick_block_size();
      // aim some requests at sizes actually stored
      if (op == OP_MATCH && stored_count > 0 && $urandom_range(99) < 40) begin
        do slot = $urandom_range(ENTRIES - 1); while (!slot_used[slot]);
        size = slot_size[slot] - SIZE_W'($urandom_range(1));
      end
      send_item(op, addr, size);
      last_addr = addr;
    end
  endtask

  task automatic test_directed();
    send_item(OP_MATCH, 32'h0000_0000, 16'd0);
    send_item(OP_MATCH, 32'h0000_0000, 16'd16383);
    send_item(OP_PUT,   32'h0000_0000, 16'd0);
    send_item(OP_PUT,   32'hFFFF_FFFF, 16'd63);
    send_item(OP_PUT,   32'h0000_1000, 16'd64);
    send_item(OP_PUT,   32'h0000_2000, 16'd255);
    send_item(OP_PUT,   32'h0000_3000, 16'd256);
    send_item(OP_PUT,   32'h0000_4000, 16'd16383);
    send_item(OP_PUT,   32'h0000_5000, 16'd16384);
    send_item(OP_PUT,   32'h0000_6000, 16'd65535);
    send_item(OP_MATCH, 32'h0000_0000, 16'd16384);
    send_item(OP_MATCH, 32'hFFFF_FFFF, 16'd65535);
    send_item(OP_PUT,   32'h0000_7000, 16'd300);
    send_item(OP_PUT,   32'h0000_8000, 16'd500);
    send_item(OP_PUT,   32'h0000_9000, 16'd400);
    // unlink from the middle of a bin, then fall through to a higher bin
    send_item(OP_MATCH, 32'h0000_0000, 16'd450);
    send_item(OP_MATCH, 32'h0000_0000, 16'd450);
    // duplicate address kept as its own block
    send_item(OP_PUT,   32'h0000_7000, 16'd300);
    send_item(OP_MATCH, 32'h0000_0000, 16'd300);
    send_item(OP_MATCH, 32'h0000_0000, 16'd300);
    send_item(OP_MATCH, 32'h0000_0000, 16'd0);
    send_item(OP_MATCH, 32'h0000_0000, 16'd100);
    send_item(OP_MATCH, 32'h0000_0000, 16'd64);
    send_item(OP_MATCH, 32'h0000_0000, 16'd1);
    send_item(OP_MATCH, 32'h0000_0000, 16'd0);
  endtask

  task automatic test_store_full();
    while (stored_count > 0) send_item(OP_MATCH, $urandom, 16'd0);
    while (stored_count < ENTRIES) send_item(OP_PUT, $urandom, SIZE_W'($urandom_range(62)));
    send_item(OP_PUT, $urandom, 16'd100);
    send_item(OP_PUT, $urandom, 16'd16384);
    // every entry is visited and none fits
    send_item(OP_MATCH, $urandom, 16'd63);
    send_item(OP_PUT, $urandom, 16'd0);
    repeat (ENTRIES / 2) send_item(OP_MATCH, $urandom, SIZE_W'($urandom_range(62)));
  endtask

  task automatic test_random_with_idling();
    in_gaps_on = 1'b1;
    out_gaps_on = 1'b1;
    run_random_traffic(450);
  endtask

  task automatic test_back_to_back();
    in_gaps_on = 1'b0;
    out_gaps_on = 1'b0;
    run_random_traffic(120);
    in_gaps_on = 1'b1;
    out_gaps_on = 1'b1;
  endtask

  task automatic test_receiver_holdoff();
    stall_request = 300;
    in_gaps_on = 1'b0;
    run_random_traffic(15);
    in_gaps_on = 1'b1;
  endtask

  task automatic test_sender_pause();
    run_random_traffic(20);
    drain_results();
    run_random_traffic(20);
  endtask

  // result side ready with random stalls and requested hold-offs
  always @(posedge clk) begin
    if (stall_request > 0) begin
      stall_left = stall_request;
      stall_request = 0;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= !(out_gaps_on && $urandom_range(99) < 33);
    end
  end

  always @(posedge clk) begin
    alloc_result_t want;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("beat with nothing pending", '0, out_tdata[ADDR_W-1:0]);
      end else begin
        want = pending_results.pop_front();
        if (out_tuser !== want.status)
          report_mismatch("status", 32'(want.status), 32'(out_tuser));
        if (out_tdata[ADDR_W-1:0] !== want.addr)
          report_mismatch("found_address", want.addr, out_tdata[ADDR_W-1:0]);
        if (out_tdata[ADDR_W +: SIZE_W] !== want.size)
          report_mismatch("found_size", 32'(want.size), 32'(out_tdata[ADDR_W +: SIZE_W]));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clear_store();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_store_full();
    test_random_with_idling();
    test_back_to_back();
    test_receiver_holdoff();
    test_sender_pause();
    run_random_traffic(120);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
